@@ src/vps_pkg.sv @@
// Shared types and command codes for the vibration pattern sequencer.
package vps_pkg;

  localparam int unsigned CntW = 8;
  localparam int unsigned TotW = 32;
  localparam int unsigned CmdW = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK      = 3'd0,
    CMD_ADD       = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_FORCE_ON  = 3'd3,
    CMD_FORCE_OFF = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [CntW-1:0] burst_count;
    logic            counted_mode;
    logic [CntW-1:0] on_ticks;
    logic [CntW-1:0] gap_ticks;
  } item_t;

  typedef struct packed {
    logic            motor_enable;
    logic            pattern_pending;
    logic [TotW-1:0] on_tick_total;
    logic [TotW-1:0] start_total;
    logic            clear_mode_pulse;
  } res_t;

  typedef struct packed {
    logic            staged_active;
    logic            staged_changed;
    logic            staged_ended;
    logic            staged_mode;
    logic [CntW-1:0] staged_bursts;
    logic [CntW-1:0] staged_on;
    logic [CntW-1:0] staged_gap;
    logic            run_active;
    logic            run_ended;
    logic            run_mode;
    logic [CntW-1:0] run_bursts;
    logic [CntW-1:0] run_on_len;
    logic [CntW-1:0] run_gap_len;
    logic [CntW-1:0] run_on_left;
    logic [CntW-1:0] run_gap_left;
    logic            was_on;
    logic            pin_level;
    logic [TotW-1:0] on_ticks_count;
    logic [TotW-1:0] starts_count;
  } state_t;

endpackage

@@ src/vps_seq.sv @@
// Pattern state registers and the per-item next-state logic.
module vps_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  vps_pkg::item_t item,
  output vps_pkg::res_t  res
);
  import vps_pkg::*;

  state_t st_r;
  state_t st_nxt;
  logic   pulse;

  always_comb begin
    st_nxt = st_r;
    pulse  = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        if (st_nxt.staged_changed) begin
          st_nxt.staged_changed = 1'b0;
          st_nxt.run_active     = st_nxt.staged_active;
          st_nxt.run_ended      = st_nxt.staged_ended;
          st_nxt.run_mode       = st_nxt.staged_mode;
          st_nxt.run_bursts     = st_nxt.staged_bursts;
          st_nxt.run_on_len     = st_nxt.staged_on;
          st_nxt.run_gap_len    = st_nxt.staged_gap;
          st_nxt.run_on_left    = st_nxt.staged_on;
          st_nxt.run_gap_left   = st_nxt.staged_gap;
        end
        if (st_nxt.run_active) begin
          if (st_nxt.was_on) begin
            st_nxt.on_ticks_count = st_nxt.on_ticks_count + TotW'(1);
          end
          if (st_nxt.run_on_left != '0) begin
            st_nxt.run_on_left = st_nxt.run_on_left - CntW'(1);
            st_nxt.pin_level   = 1'b1;
            if (!st_nxt.was_on) begin
              st_nxt.starts_count = st_nxt.starts_count + TotW'(1);
            end
            st_nxt.was_on = 1'b1;
          end else begin
            st_nxt.pin_level = 1'b0;
            st_nxt.was_on    = 1'b0;
            if (st_nxt.run_gap_left != '0) begin
              st_nxt.run_gap_left = st_nxt.run_gap_left - CntW'(1);
              if (st_nxt.run_gap_left == '0) begin
                st_nxt.run_gap_left = st_nxt.run_gap_len;
                st_nxt.run_on_left  = st_nxt.run_on_len;
                if (st_nxt.run_mode && st_nxt.run_bursts != '0) begin
                  st_nxt.run_bursts = st_nxt.run_bursts - CntW'(1);
                  if (st_nxt.run_bursts == '0) begin
                    // burst count used up: end pattern
                    st_nxt.staged_active  = 1'b0;
                    st_nxt.staged_mode    = 1'b0;
                    st_nxt.staged_bursts  = '0;
                    st_nxt.staged_on      = '0;
                    st_nxt.staged_gap     = '0;
                    st_nxt.staged_ended   = 1'b1;
                    st_nxt.staged_changed = 1'b1;
                    st_nxt.was_on         = 1'b0;
                  end
                end
              end
            end else begin
              // zero gap: end pattern
              st_nxt.staged_active  = 1'b0;
              st_nxt.staged_mode    = 1'b0;
              st_nxt.staged_bursts  = '0;
              st_nxt.staged_on      = '0;
              st_nxt.staged_gap     = '0;
              st_nxt.staged_ended   = 1'b1;
              st_nxt.staged_changed = 1'b1;
              st_nxt.was_on         = 1'b0;
            end
          end
        end else if (st_nxt.run_ended) begin
          st_nxt.pin_level = 1'b0;
          st_nxt.run_ended = 1'b0;
          st_nxt.was_on    = 1'b0;
          pulse            = 1'b1;
        end
      end
      CMD_ADD: begin
        st_nxt.staged_bursts  = item.burst_count;
        st_nxt.staged_mode    = item.counted_mode;
        st_nxt.staged_on      = item.on_ticks;
        st_nxt.staged_gap     = item.gap_ticks;
        st_nxt.staged_active  = 1'b1;
        st_nxt.staged_ended   = 1'b1;
        st_nxt.staged_changed = 1'b1;
      end
      CMD_DELETE: begin
        st_nxt.staged_active  = 1'b0;
        st_nxt.staged_mode    = 1'b0;
        st_nxt.staged_bursts  = '0;
        st_nxt.staged_on      = '0;
        st_nxt.staged_gap     = '0;
        st_nxt.staged_ended   = 1'b1;
        st_nxt.staged_changed = 1'b1;
        st_nxt.was_on         = 1'b0;
      end
      CMD_FORCE_ON, CMD_FORCE_OFF: begin
        // both patterns cleared; staged_changed and was_on kept
        st_nxt.staged_active = 1'b0;
        st_nxt.staged_ended  = 1'b0;
        st_nxt.staged_mode   = 1'b0;
        st_nxt.staged_bursts = '0;
        st_nxt.staged_on     = '0;
        st_nxt.staged_gap    = '0;
        st_nxt.run_active    = 1'b0;
        st_nxt.run_ended     = 1'b0;
        st_nxt.run_mode      = 1'b0;
        st_nxt.run_bursts    = '0;
        st_nxt.run_on_len    = '0;
        st_nxt.run_gap_len   = '0;
        st_nxt.run_on_left   = '0;
        st_nxt.run_gap_left  = '0;
        st_nxt.pin_level     = (item.cmd == CMD_FORCE_ON);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.motor_enable     = st_nxt.pin_level;
    res.pattern_pending  = st_nxt.staged_active;
    res.on_tick_total    = st_nxt.on_ticks_count;
    res.start_total      = st_nxt.starts_count;
    res.clear_mode_pulse = pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ src/vibration_pattern_sequencer.sv @@
// Top level of the vibration pattern sequencer: input register, state, result register.
//
// Usage:
//  - Input channel (in_*): one command item per handshake: tick, add pattern,
//    delete pattern, force on, force off. Accepted when in_valid is high and
//    in_stall is low at a rising edge of clk.
//  - Result channel (out_*): exactly one result item per input item, in order,
//    carrying the motor pin level, pending flag, the two wrapping totals and
//    the clear-mode pulse.
//  - Path: an accepted item is registered in the input register, processed through the
//    single-pass next-state logic and captured in the result register, which
//    raises out_valid.
//  - Throughput: one item per cycle while no result is stalled; the input register and result register
//    form a two-stage pipeline, so a new item is taken while a result waits.
//  - Stalls: while out_stall holds a result, the pipeline stops moving and
//    in_stall rises once the input register is also full. Nothing is dropped.
//  - Reset (rst_n low, synchronous): both patterns, the pin, the totals and
//    both valid flags clear; payload registers are left as they are.
module vibration_pattern_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [vps_pkg::CmdW-1:0]   in_cmd,
  input  logic [vps_pkg::CntW-1:0]   in_burst_count,
  input  logic                       in_counted_mode,
  input  logic [vps_pkg::CntW-1:0]   in_on_ticks,
  input  logic [vps_pkg::CntW-1:0]   in_gap_ticks,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_motor_enable,
  output logic                       out_pattern_pending,
  output logic [vps_pkg::TotW-1:0]   out_on_tick_total,
  output logic [vps_pkg::TotW-1:0]   out_start_total,
  output logic                       out_clear_mode_pulse
);
  import vps_pkg::*;

  logic  in_vld_r;
  item_t item_r;
  logic  out_vld_r;
  res_t  res_r;
  res_t  res_nxt;
  logic  advance;
  logic  step_en;

  // Pipeline moves when the result register is empty or being taken.
  assign advance  = !out_vld_r || !out_stall;
  assign step_en  = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.cmd          <= in_cmd;
      item_r.burst_count  <= in_burst_count;
      item_r.counted_mode <= in_counted_mode;
      item_r.on_ticks     <= in_on_ticks;
      item_r.gap_ticks    <= in_gap_ticks;
    end
  end

  // Pattern state and next-state logic
  vps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step_en(step_en),
    .item  (item_r),
    .res   (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_motor_enable     = res_r.motor_enable;
  assign out_pattern_pending  = res_r.pattern_pending;
  assign out_on_tick_total    = res_r.on_tick_total;
  assign out_start_total      = res_r.start_total;
  assign out_clear_mode_pulse = res_r.clear_mode_pulse;

  // A pattern end always leaves the motor off.
  a_pulse_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.clear_mode_pulse |-> !res_r.motor_enable)
    else $error("clear-mode pulse with motor on");

  // An end is only reported once nothing is staged.
  a_pulse_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.clear_mode_pulse |-> !res_r.pattern_pending)
    else $error("clear-mode pulse with pattern pending");

  // Back-pressure only when the input register holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled with room in the pipeline");

  // Start total moves by at most one per processed item.
  a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_stall && step_en |=>
      (res_r.start_total == $past(res_r.start_total)) ||
      (res_r.start_total == $past(res_r.start_total) + TotW'(1)))
    else $error("start total jumped");

endmodule

@@ verif/vibration_pattern_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the vibration pattern sequencer: scripted and random commands.
module vibration_pattern_sequencer_tb;
  import vps_pkg::*;

  // Random item count, and a cycle ceiling far above the slowest legal run
  // (about 680 items, each with the longest idle pause in and the longest stall out).
  localparam int unsigned RandomItems = 650;
  localparam int unsigned CycleLimit  = 400000;

  // Command codes the block must treat as no-ops.
  localparam logic [CmdW-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CmdW-1:0] CMD_SPARE_HI = 3'd7;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [CmdW-1:0] in_cmd;
  logic [CntW-1:0] in_burst_count;
  logic            in_counted_mode;
  logic [CntW-1:0] in_on_ticks;
  logic [CntW-1:0] in_gap_ticks;
  logic            out_valid;
  logic            out_stall;
  logic            out_motor_enable;
  logic            out_pattern_pending;
  logic [TotW-1:0] out_on_tick_total;
  logic [TotW-1:0] out_start_total;
  logic            out_clear_mode_pulse;

  vibration_pattern_sequencer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_burst_count      (in_burst_count),
    .in_counted_mode     (in_counted_mode),
    .in_on_ticks         (in_on_ticks),
    .in_gap_ticks        (in_gap_ticks),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_motor_enable    (out_motor_enable),
    .out_pattern_pending (out_pattern_pending),
    .out_on_tick_total   (out_on_tick_total),
    .out_start_total     (out_start_total),
    .out_clear_mode_pulse(out_clear_mode_pulse)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Motor predictor. The pending pattern is what an add has queued; the
  // current pattern is what the last copying tick loaded and now plays out.
  // ---------------------------------------------------------------------------
  logic            pend_valid, pend_dirty, pend_finish, pend_counted;
  logic [CntW-1:0] pend_bursts, pend_on, pend_gap;
  logic            cur_valid, cur_finish, cur_counted;
  logic [CntW-1:0] cur_bursts, cur_on_len, cur_gap_len, cur_on_rem, cur_gap_rem;
  logic            motor_was_on, motor_pin;
  logic [TotW-1:0] on_tick_sum, start_sum;

  function automatic void clear_pending();
    pend_valid   = 1'b0;
    pend_finish  = 1'b0;
    pend_counted = 1'b0;
    pend_bursts  = '0;
    pend_on      = '0;
    pend_gap     = '0;
  endfunction

  function automatic void clear_current();
    cur_valid   = 1'b0;
    cur_finish  = 1'b0;
    cur_counted = 1'b0;
    cur_bursts  = '0;
    cur_on_len  = '0;
    cur_gap_len = '0;
    cur_on_rem  = '0;
    cur_gap_rem = '0;
  endfunction

  // Pattern end: queue an empty, finishing pattern for the next tick to load.
  // The pin is left alone until that tick.
  function automatic void finish_pattern();
    clear_pending();
    pend_finish  = 1'b1;
    pend_dirty   = 1'b1;
    motor_was_on = 1'b0;
  endfunction

  function automatic res_t advance_motor(item_t stim);
    res_t r;
    logic pulse;
    pulse = 1'b0;
    case (stim.cmd)
      CMD_TICK: begin
        if (pend_dirty) begin
          pend_dirty  = 1'b0;
          cur_valid   = pend_valid;
          cur_finish  = pend_finish;
          cur_counted = pend_counted;
          cur_bursts  = pend_bursts;
          cur_on_len  = pend_on;
          cur_gap_len = pend_gap;
          cur_on_rem  = pend_on;
          cur_gap_rem = pend_gap;
        end
        if (cur_valid) begin
          if (motor_was_on) on_tick_sum = on_tick_sum + TotW'(1);
          if (cur_on_rem != '0) begin
            cur_on_rem = cur_on_rem - CntW'(1);
            motor_pin  = 1'b1;
            if (!motor_was_on) start_sum = start_sum + TotW'(1);
            motor_was_on = 1'b1;
          end else begin
            motor_pin    = 1'b0;
            motor_was_on = 1'b0;
            if (cur_gap_rem != '0) begin
              cur_gap_rem = cur_gap_rem - CntW'(1);
              if (cur_gap_rem == '0) begin
                cur_gap_rem = cur_gap_len;
                cur_on_rem  = cur_on_len;
                // zero bursts in counted mode never runs out
                if (cur_counted && cur_bursts != '0) begin
                  cur_bursts = cur_bursts - CntW'(1);
                  if (cur_bursts == '0) finish_pattern();
                end
              end
            end else begin
              finish_pattern();
            end
          end
        end else if (cur_finish) begin
          motor_pin    = 1'b0;
          cur_finish   = 1'b0;
          pulse        = 1'b1;
          motor_was_on = 1'b0;
        end
      end
      CMD_ADD: begin
        pend_bursts  = stim.burst_count;
        pend_counted = stim.counted_mode;
        pend_on      = stim.on_ticks;
        pend_gap     = stim.gap_ticks;
        pend_valid   = 1'b1;
        pend_finish  = 1'b1;
        pend_dirty   = 1'b1;
      end
      CMD_DELETE: finish_pattern();
      CMD_FORCE_ON: begin
        clear_pending();
        clear_current();
        motor_pin = 1'b1;
      end
      CMD_FORCE_OFF: begin
        clear_pending();
        clear_current();
        motor_pin = 1'b0;
      end
      default: ;
    endcase
    r.motor_enable     = motor_pin;
    r.pattern_pending  = pend_valid;
    r.on_tick_total    = on_tick_sum;
    r.start_total      = start_sum;
    r.clear_mode_pulse = pulse;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected results, oldest first, and bookkeeping
  // ---------------------------------------------------------------------------
  res_t        expected_q[$];
  int unsigned fail_count   = 0;
  int unsigned item_count   = 0;
  int unsigned tick_count   = 0;
  int unsigned pulse_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned cycle_count  = 0;
  bit          steady_in    = 1'b0;

  // Mostly short pauses, the odd long one; none at all in a steady stretch.
  function automatic int unsigned pick_pause(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t mk_item(logic [CmdW-1:0] cmd, logic [CntW-1:0] bursts,
                                    logic counted, logic [CntW-1:0] on_t,
                                    logic [CntW-1:0] gap_t);
    item_t it;
    it.cmd          = cmd;
    it.burst_count  = bursts;
    it.counted_mode = counted;
    it.on_ticks     = on_t;
    it.gap_ticks    = gap_t;
    return it;
  endfunction

  function automatic res_t res_of(logic pin, logic pending, logic [TotW-1:0] on_total,
                                  logic [TotW-1:0] starts, logic pulse);
    res_t r;
    r.motor_enable     = pin;
    r.pattern_pending  = pending;
    r.on_tick_total    = on_total;
    r.start_total      = starts;
    r.clear_mode_pulse = pulse;
    return r;
  endfunction

  // Present one item on the input port, hold it until taken, then record what
  // it should produce. A typed-in result overrides the predictor's, but the
  // predictor still steps so its state stays in line with the block.
  task automatic send_item(input item_t stim, input bit fixed, input res_t want);
    int unsigned pause;
    res_t        pred;
    pause = pick_pause(steady_in);
    @(negedge clk);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= stim.cmd;
    in_burst_count  <= stim.burst_count;
    in_counted_mode <= stim.counted_mode;
    in_on_ticks     <= stim.on_ticks;
    in_gap_ticks    <= stim.gap_ticks;
    do @(posedge clk); while (in_stall);
    pred = advance_motor(stim);
    expected_q.push_back(fixed ? want : pred);
    item_count++;
    if (stim.cmd == CMD_TICK) tick_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, with long stall-free stretches now and then
  // ---------------------------------------------------------------------------
  initial begin : stall_gen
    int unsigned hold;
    int unsigned r;
    logic        lvl;
    hold      = 0;
    lvl       = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          lvl  = 1'b0;
          hold = $urandom_range(30, 120);
        end else if (!lvl) begin
          lvl  = 1'b1;
          hold = (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end else begin
          lvl  = 1'b0;
          hold = $urandom_range(1, 5);
        end
      end
      hold--;
      out_stall <= lvl;
    end
  end

  // Compare every result taken against the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_stall) stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_motor_enable !== want.motor_enable) begin
          $error("motor_enable: expected %0d, got %0d", want.motor_enable, out_motor_enable);
          fail_count++;
        end
        if (out_pattern_pending !== want.pattern_pending) begin
          $error("pattern_pending: expected %0d, got %0d",
                 want.pattern_pending, out_pattern_pending);
          fail_count++;
        end
        if (out_on_tick_total !== want.on_tick_total) begin
          $error("on_tick_total: expected %0d, got %0d", want.on_tick_total, out_on_tick_total);
          fail_count++;
        end
        if (out_start_total !== want.start_total) begin
          $error("start_total: expected %0d, got %0d", want.start_total, out_start_total);
          fail_count++;
        end
        if (out_clear_mode_pulse !== want.clear_mode_pulse) begin
          $error("clear_mode_pulse: expected %0d, got %0d",
                 want.clear_mode_pulse, out_clear_mode_pulse);
          fail_count++;
        end
        if (out_clear_mode_pulse === 1'b1) pulse_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run timed out after %0d cycles, %0d items outstanding",
               cycle_count, expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: scripted rows first, then random traffic
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t stim;
    bit    fixed;
    res_t  want;
  } script_row_t;

  script_row_t script[$];

  task automatic script_row(input item_t stim, input bit fixed, input res_t want);
    script_row_t row;
    row.stim  = stim;
    row.fixed = fixed;
    row.want  = want;
    script.push_back(row);
  endtask

  initial begin : stimulus
    item_t       it;
    int unsigned r;

    in_valid        = 1'b0;
    in_cmd          = CMD_TICK;
    in_burst_count  = '0;
    in_counted_mode = 1'b0;
    in_on_ticks     = '0;
    in_gap_ticks    = '0;
    rst_n           = 1'b0;

    clear_pending();
    clear_current();
    pend_dirty   = 1'b0;
    motor_was_on = 1'b0;
    motor_pin    = 1'b0;
    on_tick_sum  = '0;
    start_sum    = '0;

    // Idle tick straight after reset: nothing running, all quiet.
    script_row(mk_item(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b1,
               res_of(1'b0, 1'b0, '0, '0, 1'b0));
    // Unused code with every field bit set must be ignored.
    script_row(mk_item(CMD_SPARE_HI, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
               res_of(1'b0, 1'b0, '0, '0, 1'b0));
    // Force on sets the pin without counting a start; force off drops it.
    script_row(mk_item(CMD_FORCE_ON, 8'h00, 1'b0, 8'h00, 8'h00), 1'b1,
               res_of(1'b1, 1'b0, '0, '0, 1'b0));
    script_row(mk_item(CMD_FORCE_OFF, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
               res_of(1'b0, 1'b0, '0, '0, 1'b0));
    // Counted pattern of two short bursts, played to its end and the clear pulse.
    script_row(mk_item(CMD_ADD, 8'd2, 1'b1, 8'd1, 8'd2), 1'b1,
               res_of(1'b0, 1'b1, '0, '0, 1'b0));
    repeat (7) script_row(mk_item(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0);
    // Counted mode with zero bursts keeps repeating; delete ends it.
    script_row(mk_item(CMD_ADD, 8'd0, 1'b1, 8'd2, 8'd1), 1'b0, '0);
    repeat (4) script_row(mk_item(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0);
    script_row(mk_item(CMD_DELETE, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b0, '0);
    script_row(mk_item(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0);
    // Zero gap ends the pattern on its first tick.
    script_row(mk_item(CMD_ADD, 8'hFF, 1'b0, 8'h00, 8'h00), 1'b0, '0);
    repeat (2) script_row(mk_item(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0);
    // Longest pattern, cut short by force on mid-burst.
    script_row(mk_item(CMD_ADD, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b0, '0);
    script_row(mk_item(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0);
    script_row(mk_item(CMD_FORCE_ON, 8'h5A, 1'b0, 8'hA5, 8'h3C), 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_item(script[i].stim, script[i].fixed, script[i].want);

    // Random part: ticks dominate so patterns get to play out; adds are
    // mostly short so bursts, gaps and counted ends happen often.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        // Let the pipe run dry before carrying on.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      if (n % 50 == 0) steady_in = ($urandom_range(0, 3) == 0);
      it.burst_count  = CntW'($urandom);
      it.counted_mode = 1'($urandom_range(0, 1));
      it.on_ticks     = CntW'($urandom);
      it.gap_ticks    = CntW'($urandom);
      r = $urandom_range(0, 99);
      if (r < 64) begin
        it.cmd = CMD_TICK;
      end else if (r < 78) begin
        it.cmd = CMD_ADD;
        if ($urandom_range(0, 9) != 0) begin
          it.on_ticks    = CntW'($urandom_range(0, 5));
          it.gap_ticks   = CntW'($urandom_range(0, 5));
          it.burst_count = CntW'($urandom_range(0, 4));
        end
      end else if (r < 86) begin
        it.cmd = CMD_DELETE;
      end else if (r < 91) begin
        it.cmd = CMD_FORCE_ON;
      end else if (r < 96) begin
        it.cmd = CMD_FORCE_OFF;
      end else begin
        it.cmd = CmdW'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      send_item(it, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d items sent (%0d scripted), %0d of them ticks; %0d motor starts, %0d on-ticks",
             item_count, script.size(), tick_count, start_sum, on_tick_sum);
    $display("%0d clear-mode pulses seen, result side stalled for %0d cycles",
             pulse_count, stall_cycles);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/vps_pkg.sv
src/vps_seq.sv
src/vibration_pattern_sequencer.sv
verif/vibration_pattern_sequencer_tb.sv
